// ----- hdl/its_pkg.sv -----
package its_pkg;

   localparam int HISTORY_DEPTH = 1024;
   localparam int HIST_ADDR_W   = $clog2(HISTORY_DEPTH);
   localparam int HIST_LEN_W    = 11;
   localparam int TS_W          = 48;
   localparam int IV_W          = 32;
   localparam int ACC_W         = 64;
   localparam int DIV_CNT_W     = $clog2(ACC_W + 1);

   localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = HIST_LEN_W'(1024);
   localparam logic [HIST_LEN_W-1:0] HIST_LEN_MAX   = HIST_LEN_W'(HISTORY_DEPTH);

   typedef enum logic [1:0] {
      FUNC_START   = 2'd0,
      FUNC_STOP    = 2'd1,
      FUNC_RESTART = 2'd2,
      FUNC_READ    = 2'd3
   } its_func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_SQUARE,
      ST_ACCUM,
      ST_LAUNCH,
      ST_WAIT,
      ST_RESULT
   } its_state_type;

endpackage

// ----- hdl/its_divider.sv -----
// Restoring divider: one quotient bit per cycle.
module its_divider
   import its_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACC_W-1:0] dividend,
   input  logic [IV_W-1:0]  divisor,
   output logic             done,
   output logic [ACC_W-1:0] quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [ACC_W-1:0]     quo_ff;
   logic [IV_W-1:0]      rem_ff;
   logic [IV_W-1:0]      divisor_ff;

   logic [IV_W:0]        rem_shift;
   logic [IV_W:0]        rem_diff;
   logic                 fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[ACC_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= DIV_CNT_W'(ACC_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[ACC_W-2:0], fits};
         rem_ff <= fits ? rem_diff[IV_W-1:0] : rem_shift[IV_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/interval_timer_statistics.sv -----
// Interval timer statistics.
// The request channel (req_valid/req_ready) carries one beat per timing event: a func code,
// a 48-bit timestamp from a free-running tick counter and a history index. Start marks the
// time; stop measures the interval since the mark and logs it; stop-and-restart does the
// same and moves the mark; read returns one entry of the recent-interval history window.
// Every request beat produces exactly one response beat on rsp_valid/rsp_ready, carrying
// the interval of this beat and the running count, min, max, mean and second moment.
// Once an interval has been logged, a request is evaluated, its interval squared, the
// statistics updated and the division launched; the two bit-serial 64-by-32 dividers then
// run side by side for the mean and second moment, and once both finish the result is
// loaded into the output register. Before anything is logged no division runs.
// The block works on one request at a time; req_ready is high whenever it is idle, even
// while a finished response still waits in the output register. If the receiver stalls,
// the next result is held back until the output register is free.
// Reset clears the statistics, the start mark and the window pointers and sets the window
// length register to 1024; the history memory itself is not cleared, since entries are
// only readable after they have been written. The user writes the window length through
// csr_wr_en/csr_wr_data only while the block is idle; the block does not enforce this.
module interval_timer_statistics
   import its_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wr_en,
   input  logic [HIST_LEN_W-1:0] csr_wr_data,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [TS_W-1:0]       req_timestamp,
   input  logic [HIST_ADDR_W-1:0] req_index,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IV_W-1:0]       rsp_interval,
   output logic                  rsp_interval_valid,
   output logic [IV_W-1:0]       rsp_sample_count,
   output logic [IV_W-1:0]       rsp_min_interval,
   output logic [IV_W-1:0]       rsp_max_interval,
   output logic [IV_W-1:0]       rsp_mean_interval,
   output logic [ACC_W-1:0]      rsp_second_moment,
   output logic [IV_W-1:0]       rsp_history_entry,
   output logic                  rsp_history_valid
);

   // Configuration and control state.
   logic [HIST_LEN_W-1:0]  hist_len_ff;
   its_state_type          state_ff, state_in;

   // Latched request beat.
   its_func_type           func_ff;
   logic [TS_W-1:0]        ts_ff;
   logic [HIST_ADDR_W-1:0] index_ff;

   // Statistics.
   logic [TS_W-1:0]        start_time_ff;
   logic                   start_valid_ff;
   logic [IV_W-1:0]        count_ff;
   logic [IV_W-1:0]        min_ff;
   logic [IV_W-1:0]        max_ff;
   logic [ACC_W-1:0]       sum_ff;
   logic [ACC_W-1:0]       sumsq_ff;
   logic [HIST_ADDR_W-1:0] head_ff;
   logic [HIST_LEN_W-1:0]  fill_ff;

   // Per-request working registers.
   logic [IV_W-1:0]        iv_ff;
   logic                   log_ff;
   logic [ACC_W-1:0]       square_ff;
   logic                   hit_ff;
   logic [IV_W-1:0]        rd_data_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic [IV_W-1:0]        rsp_interval_ff;
   logic                   rsp_interval_valid_ff;
   logic [IV_W-1:0]        rsp_count_ff;
   logic [IV_W-1:0]        rsp_min_ff;
   logic [IV_W-1:0]       rsp_max_ff;
   logic [IV_W-1:0]        rsp_mean_ff;
   logic [ACC_W-1:0]       rsp_moment_ff;
   logic [IV_W-1:0]        rsp_entry_ff;
   logic                   rsp_entry_valid_ff;

   // The history window lives in a single-port style memory with a registered read.
   logic [IV_W-1:0]        hist_mem [HISTORY_DEPTH];

   // Control strobes from the state machine.
   logic                   accept;
   logic                   do_calc;
   logic                   do_square;
   logic                   do_accum;
   logic                   div_start;
   logic                   rsp_load;

   // Datapath signals.
   logic [TS_W-1:0]        delta;
   logic [IV_W-1:0]        iv_calc;
   logic [HIST_LEN_W-1:0]  win_len;
   logic [HIST_LEN_W-1:0]  stored;
   logic                   rd_hit;
   logic [HIST_ADDR_W-1:0] rd_addr;
   logic                   mem_wr;
   logic [ACC_W:0]         sum_add;
   logic [ACC_W:0]         sumsq_add;
   logic                   mean_done;
   logic                   moment_done;
   logic [ACC_W-1:0]       mean_quo;
   logic [ACC_W-1:0]       moment_quo;
   logic [IV_W-1:0]        mean_sat;

   // Window length, clipped to the memory depth, and the number of entries visible.
   always_comb begin
      win_len = (hist_len_ff > HIST_LEN_MAX) ? HIST_LEN_MAX : hist_len_ff;
      stored  = (fill_ff < win_len) ? fill_ff : win_len;
      rd_hit  = ({1'b0, index_ff} < stored);
      // Oldest visible entry sits "stored" slots behind the head; arithmetic wraps at depth.
      rd_addr = head_ff - stored[HIST_ADDR_W-1:0] + index_ff;
      mem_wr  = do_accum && log_ff && (win_len != '0);
   end

   // Interval since the start mark, modulo 2^48, saturated to 32 bits.
   always_comb begin
      delta   = ts_ff - start_time_ff;
      iv_calc = (delta[TS_W-1:IV_W] != '0) ? '1 : delta[IV_W-1:0];
      sum_add   = {1'b0, sum_ff} + {{(ACC_W+1-IV_W){1'b0}}, iv_ff};
      sumsq_add = {1'b0, sumsq_ff} + {1'b0, square_ff};
      mean_sat  = (mean_quo[ACC_W-1:IV_W] != '0) ? '1 : mean_quo[IV_W-1:0];
   end

   // State machine: one request at a time, the result waits for the output register.
   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      do_calc   = 1'b0;
      do_square = 1'b0;
      do_accum  = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            accept = req_valid;
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            do_calc  = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            do_square = 1'b1;
            state_in  = ST_ACCUM;
         end
         ST_ACCUM: begin
            do_accum = 1'b1;
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            // With nothing logged the mean and moment are zero and no division runs.
            if (count_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // Both dividers start together and finish in the same cycle.
            if (mean_done && moment_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Window length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_len_ff <= HIST_LEN_RESET;
      end else if (csr_wr_en) begin
         hist_len_ff <= csr_wr_data;
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= its_func_type'(req_func);
         ts_ff    <= req_timestamp;
         index_ff <= req_index;
      end
   end

   // Start mark and the interval of this request.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff  <= '0;
         start_valid_ff <= 1'b0;
         log_ff         <= 1'b0;
      end else if (do_calc) begin
         log_ff <= start_valid_ff && (func_ff == FUNC_STOP || func_ff == FUNC_RESTART);
         if (func_ff == FUNC_START || func_ff == FUNC_RESTART) begin
            start_time_ff  <= ts_ff;
            start_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_calc) begin
         iv_ff  <= iv_calc;
         hit_ff <= (func_ff == FUNC_READ) && rd_hit;
      end
      if (do_square) begin
         square_ff <= ACC_W'(iv_ff) * ACC_W'(iv_ff);
      end
   end

   // History memory: read issued while the request is evaluated, written when it is logged.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         hist_mem[head_ff] <= iv_ff;
      end
      if (do_calc) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   // Statistics update for a logged interval.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else if (do_accum && log_ff) begin
         if (count_ff != '1) begin
            count_ff <= count_ff + 1'b1;
         end
         if (iv_ff < min_ff) begin
            min_ff <= iv_ff;
         end
         if (iv_ff > max_ff) begin
            max_ff <= iv_ff;
         end
         sum_ff   <= sum_add[ACC_W] ? '1 : sum_add[ACC_W-1:0];
         sumsq_ff <= sumsq_add[ACC_W] ? '1 : sumsq_add[ACC_W-1:0];
         if (win_len != '0) begin
            head_ff <= head_ff + 1'b1;
            fill_ff <= (fill_ff < win_len) ? fill_ff + 1'b1 : win_len;
         end
      end
   end

   // Mean and second moment run in parallel on identical dividers.
   its_divider u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (mean_done),
      .quotient (mean_quo)
   );

   its_divider u_moment_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sumsq_ff),
      .divisor  (count_ff),
      .done     (moment_done),
      .quotient (moment_quo)
   );

   // Output register; its valid clears when the beat is taken and nothing new is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_interval_ff       <= log_ff ? iv_ff : '0;
         rsp_interval_valid_ff <= log_ff;
         rsp_count_ff          <= count_ff;
         rsp_min_ff            <= min_ff;
         rsp_max_ff            <= max_ff;
         rsp_mean_ff           <= (count_ff != '0) ? mean_sat : '0;
         rsp_moment_ff         <= (count_ff != '0) ? moment_quo : '0;
         rsp_entry_ff          <= hit_ff ? rd_data_ff : '0;
         rsp_entry_valid_ff    <= hit_ff;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval       = rsp_interval_ff;
   assign rsp_interval_valid = rsp_interval_valid_ff;
   assign rsp_sample_count   = rsp_count_ff;
   assign rsp_min_interval   = rsp_min_ff;
   assign rsp_max_interval   = rsp_max_ff;
   assign rsp_mean_interval  = rsp_mean_ff;
   assign rsp_second_moment  = rsp_moment_ff;
   assign rsp_history_entry  = rsp_entry_ff;
   assign rsp_history_valid  = rsp_entry_valid_ff;

endmodule

// ----- tb/sv/its_stats_tb_pkg.sv -----
package its_stats_tb_pkg;
   import its_pkg::*;

   // Room for the response beats that can be owed at once.
   localparam int OWED_DEPTH = 8;

   typedef struct packed {
      logic [IV_W-1:0]  interval;
      logic             interval_valid;
      logic [IV_W-1:0]  sample_count;
      logic [IV_W-1:0]  min_interval;
      logic [IV_W-1:0]  max_interval;
      logic [IV_W-1:0]  mean_interval;
      logic [ACC_W-1:0] second_moment;
      logic [IV_W-1:0]  history_entry;
      logic             history_valid;
   } its_beat_type;

   // Tracks the timer statistics and the history window, and holds the
   // response beats that are still owed by the block.
   class its_stats_scoreboard;
      logic [HIST_LEN_W-1:0] window_cfg;
      logic [TS_W-1:0]       mark_time;
      bit                    mark_set;
      logic [IV_W-1:0]       n_logged;
      logic [IV_W-1:0]       min_seen;
      logic [IV_W-1:0]       max_seen;
      logic [ACC_W-1:0]      iv_sum;
      logic [ACC_W-1:0]      sq_sum;
      logic [IV_W-1:0]       ring [HISTORY_DEPTH];
      int unsigned           ring_head;
      int unsigned           ring_fill;
      its_beat_type          owed [OWED_DEPTH];
      int unsigned           owed_rd;
      int unsigned           owed_wr;
      int unsigned           owed_count;
      int unsigned           errors;

      function new();
         window_cfg = HIST_LEN_RESET;
         mark_time  = '0;
         mark_set   = 1'b0;
         n_logged   = '0;
         min_seen   = '1;
         max_seen   = '0;
         iv_sum     = '0;
         sq_sum     = '0;
         ring_head  = 0;
         ring_fill  = 0;
         owed_rd    = 0;
         owed_wr    = 0;
         owed_count = 0;
         errors     = 0;
      endfunction

      function void set_window(logic [HIST_LEN_W-1:0] len);
         window_cfg = len;
      endfunction

      // Lengths above the memory depth behave as the full depth.
      function int unsigned window_depth();
         return (window_cfg > HIST_LEN_MAX) ? HISTORY_DEPTH : int'(window_cfg);
      endfunction

      function int unsigned visible();
         return (ring_fill < window_depth()) ? ring_fill : window_depth();
      endfunction

      function int unsigned outstanding();
         return owed_count;
      endfunction

      function void add_owed(its_beat_type beat);
         if (owed_count == OWED_DEPTH) begin
            errors++;
            $display("%0t: more response beats owed than expected", $time);
            return;
         end
         owed[owed_wr] = beat;
         owed_wr = (owed_wr + 1) % OWED_DEPTH;
         owed_count++;
      endfunction

      static function logic [ACC_W-1:0] add_sat(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
         logic [ACC_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[ACC_W] ? '1 : s[ACC_W-1:0];
      endfunction

      function void note_request(its_func_type func, logic [TS_W-1:0] ts,
                                 logic [HIST_ADDR_W-1:0] idx);
         its_beat_type      want;
         logic [TS_W-1:0]   delta;
         logic [IV_W-1:0]   iv;
         logic [ACC_W-1:0]  wide;
         logic [ACC_W-1:0]  quot;
         int unsigned       kept;
         int unsigned       pos;
         want = '0;
         case (func) inside
            FUNC_START: begin
               mark_time = ts;
               mark_set  = 1'b1;
            end
            FUNC_STOP, FUNC_RESTART: begin
               if (mark_set) begin
                  delta = ts - mark_time;
                  iv = (delta[TS_W-1:IV_W] != '0) ? '1 : delta[IV_W-1:0];
                  if (window_depth() != 0) begin
                     ring[ring_head] = iv;
                     ring_head = (ring_head + 1) % HISTORY_DEPTH;
                     if (ring_fill < window_depth()) ring_fill++;
                     if (ring_fill > window_depth()) ring_fill = window_depth();
                  end
                  if (n_logged != '1) n_logged++;
                  if (iv < min_seen) min_seen = iv;
                  if (iv > max_seen) max_seen = iv;
                  wide   = ACC_W'(iv);
                  iv_sum = add_sat(iv_sum, wide);
                  sq_sum = add_sat(sq_sum, wide * wide);
                  want.interval       = iv;
                  want.interval_valid = 1'b1;
               end
               if (func == FUNC_RESTART) begin
                  mark_time = ts;
                  mark_set  = 1'b1;
               end
            end
            default: begin
               kept = visible();
               if (idx < kept) begin
                  pos = (ring_head + HISTORY_DEPTH - kept + idx) % HISTORY_DEPTH;
                  want.history_entry = ring[pos];
                  want.history_valid = 1'b1;
               end
            end
         endcase
         want.sample_count = n_logged;
         want.min_interval = min_seen;
         want.max_interval = max_seen;
         if (n_logged != '0) begin
            quot = iv_sum / ACC_W'(n_logged);
            want.mean_interval = (quot[ACC_W-1:IV_W] != '0) ? '1 : quot[IV_W-1:0];
            want.second_moment = sq_sum / ACC_W'(n_logged);
         end
         add_owed(want);
      endfunction

      function void compare(string field, logic [ACC_W-1:0] want_v, logic [ACC_W-1:0] got_v);
         if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want_v, got_v);
         end
      endfunction

      function void check_response(its_beat_type got);
         its_beat_type want;
         if (owed_count == 0) begin
            errors++;
            $display("%0t: response beat with no request outstanding", $time);
            return;
         end
         want = owed[owed_rd];
         owed_rd = (owed_rd + 1) % OWED_DEPTH;
         owed_count--;
         compare("interval", want.interval, got.interval);
         compare("interval_valid", want.interval_valid, got.interval_valid);
         compare("sample_count", want.sample_count, got.sample_count);
         compare("min_interval", want.min_interval, got.min_interval);
         compare("max_interval", want.max_interval, got.max_interval);
         compare("mean_interval", want.mean_interval, got.mean_interval);
         compare("second_moment", want.second_moment, got.second_moment);
         compare("history_entry", want.history_entry, got.history_entry);
         compare("history_valid", want.history_valid, got.history_valid);
      endfunction
   endclass

endpackage

// ----- tb/sv/tb.sv -----
module tb;
   import its_pkg::*;
   import its_stats_tb_pkg::*;

   localparam int RESET_CYCLES  = 9;
   // Margin for a request in flight to finish, with room to spare.
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 500000;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [HIST_LEN_W-1:0]  csr_wr_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_func;
   logic [TS_W-1:0]        req_timestamp;
   logic [HIST_ADDR_W-1:0] req_index;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [IV_W-1:0]        rsp_interval;
   logic                   rsp_interval_valid;
   logic [IV_W-1:0]        rsp_sample_count;
   logic [IV_W-1:0]        rsp_min_interval;
   logic [IV_W-1:0]        rsp_max_interval;
   logic [IV_W-1:0]        rsp_mean_interval;
   logic [ACC_W-1:0]       rsp_second_moment;
   logic [IV_W-1:0]        rsp_history_entry;
   logic                   rsp_history_valid;

   // When idling_on is low, the sender adds no random gaps and the receiver starts no new stalls.
   bit                     idling_on;
   int unsigned            sink_hold;
   int unsigned            cycle_count;
   // Free-running tick counter that the timestamps are drawn from.
   logic [TS_W-1:0]        tick;
   its_stats_scoreboard    tally;

   interval_timer_statistics u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_timestamp      (req_timestamp),
      .req_index          (req_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_interval       (rsp_interval),
      .rsp_interval_valid (rsp_interval_valid),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_min_interval   (rsp_min_interval),
      .rsp_max_interval   (rsp_max_interval),
      .rsp_mean_interval  (rsp_mean_interval),
      .rsp_second_moment  (rsp_second_moment),
      .rsp_history_entry  (rsp_history_entry),
      .rsp_history_valid  (rsp_history_valid)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Hard stop in case the block hangs or a beat never shows up.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver side. Stalls come in bursts of random length. A stall starts
   // often enough that it regularly lands on the cycle a result shows up,
   // which exercises the output register holding its beat.
   always @(negedge clock) begin
      if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
         sink_hold <= $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every response beat is checked against the oldest expectation, at the
   // rising edge that accepts it.
   always @(posedge clock) begin
      its_beat_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.interval       = rsp_interval;
         seen.interval_valid = rsp_interval_valid;
         seen.sample_count   = rsp_sample_count;
         seen.min_interval   = rsp_min_interval;
         seen.max_interval   = rsp_max_interval;
         seen.mean_interval  = rsp_mean_interval;
         seen.second_moment  = rsp_second_moment;
         seen.history_entry  = rsp_history_entry;
         seen.history_valid  = rsp_history_valid;
         tally.check_response(seen);
      end
   end

   // Sends one request beat. It is entered and left at a falling edge. Valid
   // stays high on return, so back-to-back beats never drop it; a gap or a
   // drain lowers it in a later time step.
   task automatic send_beat(its_func_type func, logic [TS_W-1:0] ts,
                            logic [HIST_ADDR_W-1:0] idx);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_func      = func;
      req_timestamp = ts;
      req_index     = idx;
      do @(posedge clock); while (!req_ready);
      tally.note_request(func, ts, idx);
      @(negedge clock);
   endtask

   // Stops sending and waits until every owed result has been received.
   task automatic drain();
      req_valid = 1'b0;
      while (tally.outstanding() != 0) @(negedge clock);
   endtask

   // The window length may only change while the block is idle, so drain and
   // then give the pipeline time to come to rest before the write.
   task automatic write_window(logic [HIST_LEN_W-1:0] len);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = len;
      @(posedge clock);
      tally.set_window(len);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [TS_W-1:0] random_stamp();
      return TS_W'({$urandom(), $urandom()});
   endfunction

   // History index for a read: mostly inside the visible window, sometimes
   // just past it, at the field extremes, or anywhere.
   function automatic logic [HIST_ADDR_W-1:0] pick_index();
      int unsigned kept;
      kept = tally.visible();
      case ($urandom_range(0, 4))
         0, 1: return (kept == 0) ? '0 : HIST_ADDR_W'($urandom_range(0, kept - 1));
         2: return HIST_ADDR_W'(kept);
         3: return ($urandom_range(0, 1) == 0) ? '0 : '1;
         default: return HIST_ADDR_W'($urandom_range(0, HISTORY_DEPTH - 1));
      endcase
   endfunction

   // Tick advance between timing events. Outside the wide-range phase the
   // steps stay small enough that the sum of squares never saturates, so the
   // second moment stays meaningful for most of the run.
   function automatic logic [TS_W-1:0] next_step(bit wide_range);
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 12)
         return TS_W'($urandom_range(0, 2000));
      else if (pick < 17)
         return TS_W'($urandom_range(0, 1 << 20));
      else if (pick < 19)
         return wide_range ? TS_W'(48'hFFFF_FFFD + $urandom_range(0, 4))
                           : TS_W'($urandom_range(0, 1 << 24));
      else
         return wide_range ? random_stamp() : '0;
   endfunction

   // Random traffic. Most of it is well-formed measurement sequences: a start
   // mark (sometimes after a jump of the tick counter), a run of stops and
   // restarts, then a few reads. Some sequences skip the start and keep
   // measuring from the previous mark, and the rest is single noise beats.
   task automatic run_traffic(int unsigned beats, bit wide_range);
      int unsigned  sent;
      its_func_type func;
      sent = 0;
      while (sent < beats) begin
         // Now and then hold off until the block has answered everything.
         if ($urandom_range(0, 59) == 0) drain();
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 5) != 0) begin
               if ($urandom_range(0, 3) == 0) tick = random_stamp();
               send_beat(FUNC_START, tick, HIST_ADDR_W'($urandom_range(0, HISTORY_DEPTH - 1)));
               sent++;
            end
            repeat ($urandom_range(1, 6)) begin
               tick = tick + next_step(wide_range);
               func = ($urandom_range(0, 1) == 0) ? FUNC_STOP : FUNC_RESTART;
               send_beat(func, tick, HIST_ADDR_W'($urandom_range(0, HISTORY_DEPTH - 1)));
               sent++;
            end
            repeat ($urandom_range(0, 3)) begin
               send_beat(FUNC_READ, tick, pick_index());
               sent++;
            end
         end else begin
            func = its_func_type'($urandom_range(0, 3));
            if (wide_range)
               tick = random_stamp();
            else
               tick = tick + TS_W'($urandom_range(0, 2000));
            send_beat(func, tick, (func == FUNC_READ) ? pick_index()
                      : HIST_ADDR_W'($urandom_range(0, HISTORY_DEPTH - 1)));
            sent++;
         end
      end
   endtask

   initial begin
      tally         = new();
      cycle_count   = 0;
      sink_hold     = 0;
      idling_on     = 1'b1;
      tick          = '0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_valid     = 1'b0;
      req_func      = FUNC_START;
      req_timestamp = '0;
      req_index     = '0;
      rsp_ready     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening with the window at its reset length. A read and a
      // stop before any start mark must leave everything at reset values.
      send_beat(FUNC_READ, 48'd0, '0);
      send_beat(FUNC_STOP, 48'd100, '0);
      // A restart without a mark logs nothing but still sets the mark.
      send_beat(FUNC_RESTART, 48'd200, '0);
      // Two stops measure from the same mark.
      send_beat(FUNC_STOP, 48'd250, '0);
      send_beat(FUNC_STOP, 48'd300, '1);
      // A zero-length interval pulls the minimum down to zero.
      send_beat(FUNC_START, 48'd1000, '0);
      send_beat(FUNC_STOP, 48'd1000, '0);
      // The interval wraps around the top of the tick counter.
      send_beat(FUNC_START, 48'hFFFF_FFFF_FFF6, '1);
      send_beat(FUNC_RESTART, 48'd5, '0);
      send_beat(FUNC_RESTART, 48'd5 + 48'h10_0000, '0);
      // Reads of the oldest and newest entry, one past the end, and the top index.
      send_beat(FUNC_READ, 48'd0, '0);
      send_beat(FUNC_READ, 48'd0, 10'd4);
      send_beat(FUNC_READ, 48'd0, 10'd5);
      send_beat(FUNC_READ, 48'd0, '1);
      tick = 48'd5 + 48'h10_0000;

      run_traffic(100, 1'b0);
      // Shrink to a single visible entry.
      write_window(11'd1);
      run_traffic(100, 1'b0);
      // Storing disabled: statistics still move, reads report nothing.
      write_window(11'd0);
      run_traffic(90, 1'b0);
      // The largest register value acts as the full memory depth.
      write_window('1);
      run_traffic(100, 1'b0);
      write_window(11'd5);
      run_traffic(100, 1'b0);
      write_window(HIST_LEN_W'($urandom_range(0, (1 << HIST_LEN_W) - 1)));
      run_traffic(100, 1'b0);

      // Last part: full window, no random stalls on either side, and intervals that
      // hit and pass the 32-bit limit. The sum of squares saturates here.
      write_window(HIST_LEN_MAX);
      idling_on = 1'b0;
      send_beat(FUNC_START, tick, '0);
      send_beat(FUNC_STOP, tick + 48'hFFFF_FFFF, '0);
      send_beat(FUNC_STOP, tick + 48'h1_0000_0000, '0);
      send_beat(FUNC_RESTART, tick + 48'hFFFF_FFFF_FFFF, '0);
      send_beat(FUNC_READ, tick, pick_index());
      tick = tick + 48'hFFFF_FFFF_FFFF;
      run_traffic(100, 1'b1);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (tally.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
